/* rtl/sprd_pkg.sv */
// Shared types, codes and constants of the stored SMS record decoder.
`default_nettype none

package sprd_pkg;

   // Most results that a single record byte can give rise to.
   localparam int MAX_RESULTS = 4;
   localparam int QUEUE_DEPTH = 4;

   // Result kinds.
   localparam logic [2:0] KIND_CENTRE = 3'd0;
   localparam logic [2:0] KIND_NUMBER = 3'd1;
   localparam logic [2:0] KIND_TIME   = 3'd2;
   localparam logic [2:0] KIND_TLEN   = 3'd3;
   localparam logic [2:0] KIND_TEXT   = 3'd4;
   localparam logic [2:0] KIND_STATUS = 3'd5;

   // Record types.
   localparam logic [1:0] MSG_OUTGOING = 2'd0;
   localparam logic [1:0] MSG_INCOMING = 2'd1;
   localparam logic [1:0] MSG_UNKNOWN  = 2'd2;
   localparam logic [1:0] MSG_DRAFT    = 2'd3;

   // Record status codes.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_HDR = 2'd1;
   localparam logic [1:0] STAT_BAD_TYP = 2'd2;

   // Raw byte values of the record layout.
   localparam logic [7:0] HEADER_BYTE  = 8'h11;
   localparam logic [7:0] INTL_TOA     = 8'h91;
   localparam logic [7:0] RAW_OUT      = 8'h05;
   localparam logic [7:0] RAW_IN_A     = 8'h01;
   localparam logic [7:0] RAW_IN_B     = 8'h03;
   localparam logic [7:0] RAW_DRAFT    = 8'h07;

   // ASCII characters.
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_DASH  = 8'h2D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_COLON = 8'h3A;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  field_kind;
      logic [15:0] value;
      logic [1:0]  msg_type;
      logic [1:0]  status;
      logic        last_of_record;
   } rsp_type;

   // All results caused by one accepted byte, in order from items[0].
   typedef struct packed {
      logic [2:0]                   count;
      rsp_type [MAX_RESULTS-1:0]    items;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

/* rtl/sprd_parse.sv */
// Front end: walks the record layout one byte at a time and builds result bundles.
`default_nettype none

module sprd_parse (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_accept,
   input  wire sprd_pkg::req_type    req_item,
   output sprd_pkg::bundle_type      bundle
);

   typedef enum logic [3:0] {
      PH_HDR0, PH_HDR1, PH_TYPE, PH_SCA_LEN, PH_SCA_TOA, PH_SCA_DIG, PH_SKIP1,
      PH_ADDR_LEN, PH_ADDR_TOA, PH_ADDR_DIG, PH_SKIP2, PH_TIME, PH_TEXT_LEN,
      PH_TEXT, PH_DONE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [1:0] record_type_ff, record_type_in;
   logic [1:0] record_status_ff, record_status_in;
   logic [2:0] time_index_ff, time_index_in;
   logic       digits_stopped_ff, digits_stopped_in;
   logic [7:0] text_high_byte_ff, text_high_byte_in;
   logic       text_odd_ff, text_odd_in;

   logic [2:0] n;
   logic [7:0] b;
   logic [3:0] lo;
   logic [3:0] hi;
   logic [2:0] digit_kind;
   logic [7:0] sep;
   logic [8:0] addr_sum;

   function automatic sprd_pkg::rsp_type mk(input logic [2:0] kind, input logic [15:0] val,
                                             input logic [1:0] rt, input logic [1:0] st,
                                             input logic last);
      sprd_pkg::rsp_type r;
      r.field_kind     = kind;
      r.value          = val;
      r.msg_type       = rt;
      r.status         = st;
      r.last_of_record = last;
      return r;
   endfunction

   assign b        = req_item.data_byte;
   assign lo       = b[3:0];
   assign hi       = b[7:4];
   assign addr_sum = {1'b0, b} + 9'd1;

   always_comb begin
      phase_in          = phase_ff;
      bytes_left_in     = bytes_left_ff;
      record_type_in    = record_type_ff;
      record_status_in  = record_status_ff;
      time_index_in     = time_index_ff;
      digits_stopped_in = digits_stopped_ff;
      text_high_byte_in = text_high_byte_ff;
      text_odd_in       = text_odd_ff;
      bundle            = '0;
      n                 = 3'd0;
      sep               = 8'h00;
      digit_kind        = (phase_ff == PH_SCA_DIG) ? sprd_pkg::KIND_CENTRE
                                                   : sprd_pkg::KIND_NUMBER;

      unique case (phase_ff) inside
         PH_HDR0: begin
            record_type_in   = sprd_pkg::MSG_UNKNOWN;
            record_status_in = sprd_pkg::STAT_BAD_HDR;
            if (b != sprd_pkg::HEADER_BYTE) begin
               phase_in = PH_DONE;
               bundle.items[n[1:0]] = mk(sprd_pkg::KIND_STATUS, 16'h0000, record_type_in,
                                         record_status_in, 1'b1);
               n = n + 3'd1;
            end else begin
               phase_in = PH_HDR1;
            end
         end
         PH_HDR1: begin
            if (b != sprd_pkg::HEADER_BYTE) begin
               phase_in = PH_DONE;
               bundle.items[n[1:0]] = mk(sprd_pkg::KIND_STATUS, 16'h0000, record_type_in,
                                         record_status_in, 1'b1);
               n = n + 3'd1;
            end else begin
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if (b == sprd_pkg::RAW_OUT) record_type_in = sprd_pkg::MSG_OUTGOING;
            else if (b == sprd_pkg::RAW_IN_A || b == sprd_pkg::RAW_IN_B)
               record_type_in = sprd_pkg::MSG_INCOMING;
            else if (b == sprd_pkg::RAW_DRAFT) record_type_in = sprd_pkg::MSG_DRAFT;
            else record_type_in = sprd_pkg::MSG_UNKNOWN;
            if (record_type_in == sprd_pkg::MSG_UNKNOWN) begin
               record_status_in = sprd_pkg::STAT_BAD_TYP;
               phase_in         = PH_DONE;
               bundle.items[n[1:0]] = mk(sprd_pkg::KIND_STATUS, 16'h0000, record_type_in,
                                         record_status_in, 1'b1);
               n = n + 3'd1;
            end else begin
               record_status_in = sprd_pkg::STAT_OK;
               phase_in         = PH_SCA_LEN;
            end
         end
         PH_SCA_LEN: begin
            if (b == 8'h00) begin
               bytes_left_in = (record_type_ff == sprd_pkg::MSG_INCOMING) ? 8'd1 : 8'd2;
               phase_in      = PH_SKIP1;
            end else begin
               bytes_left_in = b - 8'd1;
               phase_in      = PH_SCA_TOA;
            end
         end
         PH_SCA_TOA, PH_ADDR_TOA: begin
            digits_stopped_in = 1'b0;
            if (b == sprd_pkg::INTL_TOA) begin
               bundle.items[n[1:0]] = mk((phase_ff == PH_SCA_TOA) ? sprd_pkg::KIND_CENTRE
                                                                 : sprd_pkg::KIND_NUMBER,
                                         {8'h00, sprd_pkg::CHR_PLUS}, record_type_ff,
                                         sprd_pkg::STAT_OK, 1'b0);
               n = n + 3'd1;
            end
            if (phase_ff == PH_SCA_TOA) begin
               if (bytes_left_ff == 8'd0) begin
                  bytes_left_in = (record_type_ff == sprd_pkg::MSG_INCOMING) ? 8'd1 : 8'd2;
                  phase_in      = PH_SKIP1;
               end else begin
                  phase_in = PH_SCA_DIG;
               end
            end else begin
               if (bytes_left_ff == 8'd0) begin
                  bytes_left_in = (record_type_ff == sprd_pkg::MSG_DRAFT) ? 8'd3 : 8'd2;
                  phase_in      = PH_SKIP2;
               end else begin
                  phase_in = PH_ADDR_DIG;
               end
            end
         end
         PH_SCA_DIG, PH_ADDR_DIG: begin
            // Low nibble first; the first non-decimal nibble ends the address.
            if (!digits_stopped_ff) begin
               if (lo > 4'd9) begin
                  digits_stopped_in = 1'b1;
               end else begin
                  bundle.items[n[1:0]] = mk(digit_kind, {8'h00, sprd_pkg::CHR_ZERO + {4'h0, lo}},
                                            record_type_ff, sprd_pkg::STAT_OK, 1'b0);
                  n = n + 3'd1;
                  if (hi > 4'd9) begin
                     digits_stopped_in = 1'b1;
                  end else begin
                     bundle.items[n[1:0]] = mk(digit_kind,
                                               {8'h00, sprd_pkg::CHR_ZERO + {4'h0, hi}},
                                               record_type_ff, sprd_pkg::STAT_OK, 1'b0);
                     n = n + 3'd1;
                  end
               end
            end
            if (bytes_left_ff != 8'd0) bytes_left_in = bytes_left_ff - 8'd1;
            if (bytes_left_in == 8'd0) begin
               if (phase_ff == PH_SCA_DIG) begin
                  bytes_left_in = (record_type_ff == sprd_pkg::MSG_INCOMING) ? 8'd1 : 8'd2;
                  phase_in      = PH_SKIP1;
               end else begin
                  bytes_left_in = (record_type_ff == sprd_pkg::MSG_DRAFT) ? 8'd3 : 8'd2;
                  phase_in      = PH_SKIP2;
               end
            end
         end
         PH_SKIP1: begin
            if (bytes_left_ff != 8'd0) bytes_left_in = bytes_left_ff - 8'd1;
            if (bytes_left_in == 8'd0) phase_in = PH_ADDR_LEN;
         end
         PH_ADDR_LEN: begin
            if (b == 8'h00) begin
               bytes_left_in = (record_type_ff == sprd_pkg::MSG_DRAFT) ? 8'd3 : 8'd2;
               phase_in      = PH_SKIP2;
            end else begin
               bytes_left_in = addr_sum[8:1];
               phase_in      = PH_ADDR_TOA;
            end
         end
         PH_SKIP2: begin
            if (bytes_left_ff != 8'd0) bytes_left_in = bytes_left_ff - 8'd1;
            if (bytes_left_in == 8'd0) begin
               if (record_type_ff == sprd_pkg::MSG_INCOMING) begin
                  time_index_in = 3'd0;
                  phase_in      = PH_TIME;
               end else begin
                  phase_in = PH_TEXT_LEN;
               end
            end
         end
         PH_TIME: begin
            // Six shown bytes as YY-MM-DD hh:mm:ss; the zone byte is skipped.
            if (time_index_ff < 3'd6) begin
               bundle.items[n[1:0]] = mk(sprd_pkg::KIND_TIME,
                                         {8'h00, sprd_pkg::CHR_ZERO + {4'h0, lo}},
                                         record_type_ff, sprd_pkg::STAT_OK, 1'b0);
               n = n + 3'd1;
               bundle.items[n[1:0]] = mk(sprd_pkg::KIND_TIME,
                                         {8'h00, sprd_pkg::CHR_ZERO + {4'h0, hi}},
                                         record_type_ff, sprd_pkg::STAT_OK, 1'b0);
               n = n + 3'd1;
               if (time_index_ff < 3'd2) sep = sprd_pkg::CHR_DASH;
               else if (time_index_ff == 3'd2) sep = sprd_pkg::CHR_SPACE;
               else if (time_index_ff < 3'd5) sep = sprd_pkg::CHR_COLON;
               if (sep != 8'h00) begin
                  bundle.items[n[1:0]] = mk(sprd_pkg::KIND_TIME, {8'h00, sep},
                                            record_type_ff, sprd_pkg::STAT_OK, 1'b0);
                  n = n + 3'd1;
               end
               time_index_in = time_index_ff + 3'd1;
            end else begin
               phase_in = PH_TEXT_LEN;
            end
         end
         PH_TEXT_LEN: begin
            bundle.items[n[1:0]] = mk(sprd_pkg::KIND_TLEN, {9'h000, b[7:1]},
                                      record_type_ff, sprd_pkg::STAT_OK, 1'b0);
            n = n + 3'd1;
            text_odd_in = 1'b0;
            if (b == 8'h00) begin
               phase_in = PH_DONE;
               bundle.items[n[1:0]] = mk(sprd_pkg::KIND_STATUS, 16'h0000, record_type_ff,
                                         record_status_ff, 1'b1);
               n = n + 3'd1;
            end else begin
               bytes_left_in = b;
               phase_in      = PH_TEXT;
            end
         end
         PH_TEXT: begin
            if (!text_odd_ff) begin
               text_high_byte_in = b;
               text_odd_in       = 1'b1;
            end else begin
               bundle.items[n[1:0]] = mk(sprd_pkg::KIND_TEXT, {text_high_byte_ff, b},
                                         record_type_ff, sprd_pkg::STAT_OK, 1'b0);
               n = n + 3'd1;
               text_odd_in = 1'b0;
            end
            if (bytes_left_ff != 8'd0) bytes_left_in = bytes_left_ff - 8'd1;
            if (bytes_left_in == 8'd0) begin
               phase_in = PH_DONE;
               bundle.items[n[1:0]] = mk(sprd_pkg::KIND_STATUS, 16'h0000, record_type_ff,
                                         record_status_ff, 1'b1);
               n = n + 3'd1;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // A record cut short still gets its closing status after this byte's results.
      if (req_item.frame_end) begin
         if (phase_in != PH_DONE) begin
            bundle.items[n[1:0]] = mk(sprd_pkg::KIND_STATUS, 16'h0000, record_type_in,
                                      record_status_in, 1'b1);
            n = n + 3'd1;
         end
         phase_in = PH_HDR0;
      end

      bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HDR0;
         bytes_left_ff     <= 8'd0;
         record_type_ff    <= 2'd0;
         record_status_ff  <= 2'd0;
         time_index_ff     <= 3'd0;
         digits_stopped_ff <= 1'b0;
         text_high_byte_ff <= 8'd0;
         text_odd_ff       <= 1'b0;
      end else if (req_accept) begin
         phase_ff          <= phase_in;
         bytes_left_ff     <= bytes_left_in;
         record_type_ff    <= record_type_in;
         record_status_ff  <= record_status_in;
         time_index_ff     <= time_index_in;
         digits_stopped_ff <= digits_stopped_in;
         text_high_byte_ff <= text_high_byte_in;
         text_odd_ff       <= text_odd_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/sprd_queue.sv */
// Short bundle queue between the parsing front end and the result emitter.
`default_nettype none

module sprd_queue #(
   parameter int Depth = sprd_pkg::QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire sprd_pkg::bundle_type      push_data,
   input  wire logic                      pop,
   output sprd_pkg::bundle_type           head,
   output sprd_pkg::queue_status_type     status
);

   localparam int PTR_W = $clog2(Depth);
   localparam int CNT_W = $clog2(Depth + 1);

   sprd_pkg::bundle_type mem [Depth];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_data;
   end

   assign head         = mem[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(Depth));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

/* rtl/sprd_emit.sv */
// Back end: unpacks queued bundles into single results behind an output register.
`default_nettype none

module sprd_emit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sprd_pkg::bundle_type      head,
   input  wire sprd_pkg::queue_status_type q_status,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output sprd_pkg::rsp_type              rsp_payload
);

   localparam int IDX_W = $clog2(sprd_pkg::MAX_RESULTS);

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              valid_ff, valid_in;
   sprd_pkg::rsp_type data_ff, data_in;
   logic              load;
   logic              last_item;

   assign load      = !q_status.empty && (!valid_ff || rsp_ready);
   assign last_item = (3'({1'b0, idx_ff}) + 3'd1) == head.count;
   assign pop       = load && last_item;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         data_in  = head.items[idx_ff];
         valid_in = 1'b1;
         idx_in   = last_item ? '0 : idx_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("bundle popped from an empty queue");

   a_bundle_count: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (head.count != 3'd0 &&
                           head.count <= 3'(sprd_pkg::MAX_RESULTS)))
      else $error("queued bundle holds no results or too many");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (3'({1'b0, idx_ff}) < head.count))
      else $error("result index beyond the head bundle");

   a_idx_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == '0)
      else $error("result index not rewound after a bundle completed");

endmodule

`default_nettype wire

/* rtl/sms_pdu_record_decoder.sv */
// Top level of the stored SMS record decoder.
`default_nettype none

// Decodes a stored SMS record presented one byte per transaction on the req_
// channel and delivers the decoded characters, text length, UCS-2 text units and
// a closing status as rsp_ transactions. A byte is taken every cycle while the
// bundle queue (QueueDepth entries, each holding all results of one byte) has
// room; bytes that cause no result never occupy it. Results leave through a
// single output register at one per cycle while rsp_ready is high, so a stream
// of bytes giving at most one result each then runs at one byte per cycle, while
// timestamp bytes (up to three results) and closing bytes (up to four) hold the
// output for each of their results in turn and stall input once the queue fills.
// An accepted byte's results pass the bundle queue, then the output register.
module sms_pdu_record_decoder #(
   parameter int QueueDepth = sprd_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire sprd_pkg::req_type  req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output sprd_pkg::rsp_type       rsp_payload
);

   sprd_pkg::bundle_type       bundle;
   sprd_pkg::bundle_type       head;
   sprd_pkg::queue_status_type q_status;
   logic                       req_accept;
   logic                       push;
   logic                       pop;

   assign req_ready  = !q_status.full;
   assign req_accept = req_valid && req_ready;
   assign push       = req_accept && (bundle.count != 3'd0);

   sprd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_item   (req_payload),
      .bundle     (bundle)
   );

   sprd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   sprd_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
